// ----- rtl/rrd_pkg.sv -----
// Shared types and constants for the rational reduce and divide block.
package rrd_pkg;

   localparam int unsigned WIDTH_DEFAULT = 32;
   localparam int unsigned FIELD_W       = 32;
   localparam int unsigned DEN_W         = 31;
   localparam int unsigned PROD_W        = 64;
   localparam int unsigned CNT_W         = 7;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_DIV_ZERO = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic {
      OP_NORMALIZE = 1'b0,
      OP_DIVIDE    = 1'b1
   } op_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture operands, form magnitudes
      logic mul_lo;      // first half of cross products
      logic mul_hi;      // second half of cross products
      logic gcd_step;    // not driven by the controller nor read by the datapath
      logic rem_init;    // set up restoring division of x by y
      logic rem_bit;     // one quotient bit
      logic rem_done;    // y <- remainder
      logic div_init;    // start dividing n and d by g
      logic div_bit;
      logic finish;      // form result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       y_zero;
      logic       n_zero;
      logic       last_bit;
      status_type early;
   } stat_type;

endpackage

// ----- rtl/rrd_datapath.sv -----
// Datapath: operand magnitudes, cross products, GCD by bit-serial remainder, reduction.
module rrd_datapath import rrd_pkg::*; #(
   parameter int unsigned WIDTH = WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   input  logic                      req_op,
   input  logic signed [FIELD_W-1:0] req_a_num,
   input  logic signed [FIELD_W-1:0] req_a_den,
   input  logic signed [FIELD_W-1:0] req_b_num,
   input  logic signed [FIELD_W-1:0] req_b_den,
   output logic signed [FIELD_W-1:0] res_num,
   output logic        [DEN_W-1:0]   res_den,
   output status_type                res_status
);

   localparam logic [PROD_W-1:0] LIM = (PROD_W'(1) << (WIDTH - 1)) - PROD_W'(1);

   logic [FIELD_W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic               op_ff, neg_ff;
   logic [PROD_W-1:0]  n_ff, d_ff, x_ff, y_ff, r_ff, q_ff, q2_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               phase_ff;   // at div_init, 0: load n, 1: load d
   status_type         early_ff;
   logic signed [FIELD_W-1:0] rn_ff;
   logic [DEN_W-1:0]   rd_ff;
   status_type         rs_ff;

   function automatic logic [FIELD_W-1:0] mag(input logic [FIELD_W-1:0] v);
      return v[FIELD_W-1] ? (~v + FIELD_W'(1)) : v;
   endfunction

   logic [PROD_W-1:0] rem_shift, rem_sub;
   logic [PROD_W-1:0] dvd, dvs;
   logic [PROD_W:0]   trial;
   assign dvs   = cmd.div_bit ? x_ff : y_ff;
   assign dvd   = q_ff;
   assign rem_shift = {r_ff[PROD_W-2:0], dvd[PROD_W-1]};
   assign trial = {1'b0, rem_shift} - {1'b0, dvs};
   assign rem_sub = trial[PROD_W] ? rem_shift : trial[PROD_W-1:0];

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   assign mul_a = cmd.mul_lo ? an_ff : ad_ff;
   assign mul_b = cmd.mul_lo ? bd_ff : bn_ff;
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         an_ff  <= mag(req_a_num);
         ad_ff  <= mag(req_a_den);
         bn_ff  <= mag(req_b_num);
         bd_ff  <= mag(req_b_den);
         neg_ff <= req_a_num[FIELD_W-1] ^ req_a_den[FIELD_W-1]
                   ^ (req_op & (req_b_num[FIELD_W-1] ^ req_b_den[FIELD_W-1]));
         if (req_a_den == '0 || (req_op && req_b_den == '0))
            early_ff <= STATUS_ZERO_DEN;
         else if (req_op && req_b_num == '0)
            early_ff <= STATUS_DIV_ZERO;
         else
            early_ff <= STATUS_OK;
      end
      if (cmd.mul_lo) begin
         n_ff <= op_ff ? mul_p : PROD_W'(an_ff);
      end
      if (cmd.mul_hi) begin
         d_ff <= op_ff ? mul_p : PROD_W'(ad_ff);
         x_ff <= n_ff;
         y_ff <= op_ff ? mul_p : PROD_W'(ad_ff);
      end
      if (cmd.rem_init) begin
         q_ff   <= x_ff;
         r_ff   <= '0;
         cnt_ff <= '0;
      end
      if (cmd.rem_bit || cmd.div_bit) begin
         q_ff   <= {q_ff[PROD_W-2:0], ~trial[PROD_W]};
         r_ff   <= rem_sub;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.rem_done) begin
         x_ff <= y_ff;
         y_ff <= r_ff;
      end
      if (cmd.div_init) begin
         q_ff     <= phase_ff ? d_ff : n_ff;
         r_ff     <= '0;
         cnt_ff   <= '0;
         if (phase_ff) q2_ff <= q_ff;
      end
      if (cmd.finish) begin
         rs_ff <= early_ff;
         rn_ff <= '0;
         rd_ff <= DEN_W'(1);
         if (early_ff == STATUS_OK && n_ff != '0) begin
            if (q2_ff > LIM || q_ff > LIM) begin
               rs_ff <= STATUS_OVERFLOW;
            end else begin
               rn_ff <= neg_ff ? -FIELD_W'(q2_ff) : FIELD_W'(q2_ff);
               rd_ff <= DEN_W'(q_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else if (cmd.load) begin
         phase_ff <= 1'b0;
      end else if (cmd.div_init) begin
         phase_ff <= ~phase_ff;
      end
   end

   assign stat.y_zero   = (y_ff == '0);
   assign stat.n_zero   = (n_ff == '0);
   assign stat.last_bit = (cnt_ff == CNT_W'(PROD_W - 1));
   assign stat.early    = early_ff;

   assign res_num    = rn_ff;
   assign res_den    = rd_ff;
   assign res_status = rs_ff;

endmodule

// ----- rtl/rrd_control.sv -----
// Controller state machine sequencing load, multiply, GCD and reduction.
module rrd_control import rrd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output logic     rsp_valid,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MUL1  = 10'b0000000010,
      S_MUL2  = 10'b0000000100,
      S_CHECK = 10'b0000001000,
      S_REM   = 10'b0000010000,
      S_RDONE = 10'b0000100000,
      S_DINIT = 10'b0001000000,
      S_DIV   = 10'b0010000000,
      S_FIN   = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      second_ff, second_in;

   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            if (stat.early != STATUS_OK || stat.n_zero) begin
               state_in = S_FIN;
            end else if (stat.y_zero) begin
               second_in = 1'b0;
               state_in  = S_DINIT;
            end else begin
               cmd.rem_init = 1'b1;
               state_in     = S_REM;
            end
         end
         S_REM: begin
            cmd.rem_bit = 1'b1;
            if (stat.last_bit) state_in = S_RDONE;
         end
         S_RDONE: begin
            cmd.rem_done = 1'b1;
            state_in     = S_CHECK;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_bit = 1'b1;
            if (stat.last_bit) begin
               if (second_ff) begin
                  state_in = S_FIN;
               end else begin
                  second_in = 1'b1;
                  state_in  = S_DINIT;
               end
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_out_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");
   a_fin_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN |=> rsp_valid) else $error("finish without strobe");

endmodule

// ----- rtl/rational_reduce_and_divide.sv -----
// Top level: rational normalize / divide with GCD reduction.
//  channel | ports                                   | handshake
//  request | req_op, req_a_num/den, req_b_num/den    | start & !busy
//  result  | rsp_res_num, rsp_res_den, rsp_status    | rsp_valid, one cycle
// Errors and a zero numerator go straight to the result; otherwise each Euclid
// step and the two final divisions of n and d by the GCD run on the
// bit-serial 64-bit restoring divider shared by all steps.
// Synchronous reset returns the controller to idle; results cannot be stalled.
module rational_reduce_and_divide import rrd_pkg::*; #(
   parameter int unsigned WIDTH = WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_op,
   input  logic signed [FIELD_W-1:0] req_a_num,
   input  logic signed [FIELD_W-1:0] req_a_den,
   input  logic signed [FIELD_W-1:0] req_b_num,
   input  logic signed [FIELD_W-1:0] req_b_den,
   output logic                      rsp_valid,
   output logic signed [FIELD_W-1:0] rsp_res_num,
   output logic        [DEN_W-1:0]   rsp_res_den,
   output logic        [1:0]         rsp_status
);

   cmd_type    cmd;
   stat_type   stat;
   status_type st;

   rrd_control u_ctl (
      .clock, .reset, .start, .busy, .rsp_valid, .cmd, .stat
   );

   rrd_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock, .reset, .cmd, .stat,
      .req_op, .req_a_num, .req_a_den, .req_b_num, .req_b_den,
      .res_num(rsp_res_num), .res_den(rsp_res_den), .res_status(st)
   );

   assign rsp_status = st;

endmodule
